// ----- sv/ftm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes, reset values and helper functions for the flight
// termination monitor. No dependencies.
package ftm_pkg;

    // Widths of payload fields and parameter defaults
    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int ACCEL_WIDTH_DEF = 16;
    localparam int ANGLE_MAX_W     = 32;
    localparam int MAG_W           = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WARN_PITCH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_ROLL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PANIC_PITCH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PANIC_ROLL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_TO_PANIC = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEADMAN      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FREEFALL     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 3'd7;

    // Configuration reset values
    localparam logic [31:0] RST_WARN_BOUNDS   = 32'd214823731;
    localparam logic [31:0] RST_PANIC_BOUNDS  = 32'd536928256;
    localparam logic [15:0] RST_WARN_TO_PANIC = 16'd2000;
    localparam logic [15:0] RST_DEADMAN       = 16'd1500;
    localparam logic [31:0] RST_FREEFALL      = 32'd300;
    localparam logic [9:0]  RST_TIME_STEP     = 10'd100;

    // Autopilot status codes carried by a heartbeat
    localparam logic [7:0] STS_BOOT        = 8'd1;
    localparam logic [7:0] STS_CALIBRATING = 8'd2;
    localparam logic [7:0] STS_STANDBY     = 8'd3;
    localparam logic [7:0] STS_ACTIVE      = 8'd4;
    localparam logic [7:0] STS_CRITICAL    = 8'd5;
    localparam logic [7:0] STS_EMERGENCY   = 8'd6;
    localparam logic [7:0] STS_TERMINATION = 8'd8;

    // Reported mode codes
    localparam logic [2:0] MC_UNINIT  = 3'd0;
    localparam logic [2:0] MC_BOOT    = 3'd1;
    localparam logic [2:0] MC_CAL     = 3'd2;
    localparam logic [2:0] MC_STANDBY = 3'd3;
    localparam logic [2:0] MC_ACTIVE  = 3'd4;
    localparam logic [2:0] MC_EMERG   = 3'd5;
    localparam logic [2:0] MC_TERM    = 3'd6;

    typedef enum logic [1:0] {
        CMD_HEARTBEAT = 2'd0,
        CMD_ATTITUDE  = 2'd1,
        CMD_ACCEL     = 2'd2,
        CMD_TICK      = 2'd3
    } t_cmd;

    // Tracked autopilot mode, one-hot
    typedef enum logic [6:0] {
        MODE_UNINIT  = 7'b0000001,
        MODE_BOOT    = 7'b0000010,
        MODE_CAL     = 7'b0000100,
        MODE_STANDBY = 7'b0001000,
        MODE_ACTIVE  = 7'b0010000,
        MODE_EMERG   = 7'b0100000,
        MODE_TERM    = 7'b1000000
    } t_mode;

    typedef struct packed {
        logic [31:0] warn_pitch_bounds;
        logic [31:0] warn_roll_bounds;
        logic [31:0] panic_pitch_bounds;
        logic [31:0] panic_roll_bounds;
        logic [15:0] panic_delay_ms;
        logic [15:0] deadman_ms;
        logic [31:0] freefall_threshold;
        logic [9:0]  time_step;
    } t_cfg;

    // Stage-one result: decoded event with window checks and magnitude
    typedef struct packed {
        t_cmd              cmd;
        logic [7:0]        system_status;
        logic              warn_ok;
        logic              panic_ok;
        logic [MAG_W-1:0]  mag;
    } t_pre;

    typedef struct packed {
        logic       fire;
        logic       disarm_pulse;
        logic       rearm_pulse;
        logic       armed;
        logic       warning;
        logic [2:0] mode;
    } t_res;

    // Strict window test: min < angle < max, bounds packed as two Q3.12 halves
    function automatic logic in_window(input logic signed [ANGLE_MAX_W-1:0] a,
                                       input logic [31:0] bounds);
        logic signed [ANGLE_MAX_W-1:0] lo;
        logic signed [ANGLE_MAX_W-1:0] hi;
        lo = ANGLE_MAX_W'($signed(bounds[15:0]));
        hi = ANGLE_MAX_W'($signed(bounds[31:16]));
        return (a > lo) && (a < hi);
    endfunction

    // Add a time step to a 16-bit elapsed counter, saturating at all ones
    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [9:0] b);
        logic [16:0] s;
        s = {1'b0, a} + 17'(b);
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        unique case (m)
            MODE_UNINIT:  c = MC_UNINIT;
            MODE_BOOT:    c = MC_BOOT;
            MODE_CAL:     c = MC_CAL;
            MODE_STANDBY: c = MC_STANDBY;
            MODE_ACTIVE:  c = MC_ACTIVE;
            MODE_EMERG:   c = MC_EMERG;
            MODE_TERM:    c = MC_TERM;
            default:      c = MC_UNINIT;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/ftm_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for monitor events and monitor results.
// Depends on ftm_pkg for default field widths.
interface ftm_in_if #(
    parameter int ANGLE_WIDTH = ftm_pkg::ANGLE_WIDTH_DEF,
    parameter int ACCEL_WIDTH = ftm_pkg::ACCEL_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic [1:0]                     command;
    logic [7:0]                     system_status;
    logic signed [ANGLE_WIDTH-1:0]  pitch;
    logic signed [ANGLE_WIDTH-1:0]  roll;
    logic signed [ACCEL_WIDTH-1:0]  accel_x;
    logic signed [ACCEL_WIDTH-1:0]  accel_y;
    logic signed [ACCEL_WIDTH-1:0]  accel_z;

    modport source (
        output valid, command, system_status, pitch, roll, accel_x, accel_y, accel_z,
        input  ready
    );
    modport sink (
        input  valid, command, system_status, pitch, roll, accel_x, accel_y, accel_z,
        output ready
    );
endinterface

interface ftm_out_if;
    logic       valid;
    logic       ready;
    logic       fire;
    logic       disarm_pulse;
    logic       rearm_pulse;
    logic       armed;
    logic       warning;
    logic [2:0] mode;

    modport source (
        output valid, fire, disarm_pulse, rearm_pulse, armed, warning, mode,
        input  ready
    );
    modport sink (
        input  valid, fire, disarm_pulse, rearm_pulse, armed, warning, mode,
        output ready
    );
endinterface

// ----- sv/flight_termination_monitor_core.sv -----
`timescale 1ns / 1ps
// Flight termination monitor top level. An accepted event passes through the
// input stage register, then the result register, before its result is offered.
// Throughput: one event per cycle while the result channel is not stalled.
// Reset: synchronous, active low; clears the mode to uninitialized, the arm
// flag, counters and deadman, and loads the configuration defaults.
module flight_termination_monitor_core #(
    parameter int ANGLE_WIDTH = ftm_pkg::ANGLE_WIDTH_DEF,
    parameter int ACCEL_WIDTH = ftm_pkg::ACCEL_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ftm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ftm_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    ftm_in_if.sink                          i_evt,
    ftm_out_if.source                       o_res
);
    import ftm_pkg::*;

    t_cfg cfg;
    t_pre pre;
    t_res res;
    logic pre_valid;
    logic res_valid;
    logic adv;
    logic load;

    // Advance when the result register is free or being drained
    assign adv          = !res_valid || o_res.ready;
    assign i_evt.ready  = !pre_valid || adv;
    assign load         = i_evt.valid && i_evt.ready;

    ftm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ftm_pre #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .ACCEL_WIDTH (ACCEL_WIDTH)
    ) u_pre (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_adv           (adv),
        .i_command       (i_evt.command),
        .i_system_status (i_evt.system_status),
        .i_pitch         (i_evt.pitch),
        .i_roll          (i_evt.roll),
        .i_accel_x       (i_evt.accel_x),
        .i_accel_y       (i_evt.accel_y),
        .i_accel_z       (i_evt.accel_z),
        .i_cfg           (cfg),
        .o_valid         (pre_valid),
        .o_pre           (pre)
    );

    ftm_update u_update (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (pre_valid),
        .i_pre   (pre),
        .i_cfg   (cfg),
        .o_valid (res_valid),
        .o_res   (res)
    );

    // Drive the result channel
    assign o_res.valid        = res_valid;
    assign o_res.fire         = res.fire;
    assign o_res.disarm_pulse = res.disarm_pulse;
    assign o_res.rearm_pulse  = res.rearm_pulse;
    assign o_res.armed        = res.armed;
    assign o_res.warning      = res.warning;
    assign o_res.mode         = res.mode;

    // Back-pressure reaches the input only when both stages are full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_evt.ready |-> (pre_valid && res_valid && !o_res.ready))
        else $error("input stalled while a stage is free");

    // Rearm leaves the output armed in active mode
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.rearm_pulse) |-> (o_res.armed && o_res.mode == MC_ACTIVE))
        else $error("rearm without armed active mode");

    // Disarm leaves the output disarmed in standby
    a_disarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.disarm_pulse) |->
            (!o_res.armed && !o_res.rearm_pulse && o_res.mode == MC_STANDBY))
        else $error("disarm inconsistent with arm flag or mode");

endmodule

// ----- sv/ftm_cfg.sv -----
`timescale 1ns / 1ps
// Configuration register file of the monitor: eight write-only registers.
// Depends on ftm_pkg.
module ftm_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ftm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ftm_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    output ftm_pkg::t_cfg                       o_cfg
);
    import ftm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the register index and merge write data
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WARN_PITCH:    n_cfg.warn_pitch_bounds  = i_cfg_wdata;
                REG_WARN_ROLL:     n_cfg.warn_roll_bounds   = i_cfg_wdata;
                REG_PANIC_PITCH:   n_cfg.panic_pitch_bounds = i_cfg_wdata;
                REG_PANIC_ROLL:    n_cfg.panic_roll_bounds  = i_cfg_wdata;
                REG_WARN_TO_PANIC: n_cfg.panic_delay_ms     = i_cfg_wdata[15:0];
                REG_DEADMAN:       n_cfg.deadman_ms         = i_cfg_wdata[15:0];
                REG_FREEFALL:      n_cfg.freefall_threshold = i_cfg_wdata;
                REG_TIME_STEP:     n_cfg.time_step          = i_cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warn_pitch_bounds  <= RST_WARN_BOUNDS;
            r_cfg.warn_roll_bounds   <= RST_WARN_BOUNDS;
            r_cfg.panic_pitch_bounds <= RST_PANIC_BOUNDS;
            r_cfg.panic_roll_bounds  <= RST_PANIC_BOUNDS;
            r_cfg.panic_delay_ms     <= RST_WARN_TO_PANIC;
            r_cfg.deadman_ms         <= RST_DEADMAN;
            r_cfg.freefall_threshold <= RST_FREEFALL;
            r_cfg.time_step          <= RST_TIME_STEP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/ftm_pre.sv -----
`timescale 1ns / 1ps
// Input register stage: window checks on attitude and squared acceleration
// magnitude, registered with the event command. Depends on ftm_pkg.
module ftm_pre #(
    parameter int ANGLE_WIDTH = ftm_pkg::ANGLE_WIDTH_DEF,
    parameter int ACCEL_WIDTH = ftm_pkg::ACCEL_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  logic                            i_adv,
    input  logic [1:0]                      i_command,
    input  logic [7:0]                      i_system_status,
    input  logic signed [ANGLE_WIDTH-1:0]   i_pitch,
    input  logic signed [ANGLE_WIDTH-1:0]   i_roll,
    input  logic signed [ACCEL_WIDTH-1:0]   i_accel_x,
    input  logic signed [ACCEL_WIDTH-1:0]   i_accel_y,
    input  logic signed [ACCEL_WIDTH-1:0]   i_accel_z,
    input  ftm_pkg::t_cfg                   i_cfg,
    output logic                            o_valid,
    output ftm_pkg::t_pre                   o_pre
);
    import ftm_pkg::*;

    localparam int SQ_W = 2 * ACCEL_WIDTH;

    logic                           r_valid;
    t_pre                           r_pre;
    t_pre                           n_pre;
    logic signed [ANGLE_MAX_W-1:0]  pitch_ext;
    logic signed [ANGLE_MAX_W-1:0]  roll_ext;
    logic signed [SQ_W-1:0]         sq_x;
    logic signed [SQ_W-1:0]         sq_y;
    logic signed [SQ_W-1:0]         sq_z;
    logic [SQ_W-1:0]                mag;

    // Sign-extend angles to the common compare width
    assign pitch_ext = ANGLE_MAX_W'(i_pitch);
    assign roll_ext  = ANGLE_MAX_W'(i_roll);

    // Squares are non-negative and their sum fits in twice the sample width
    assign sq_x = SQ_W'(i_accel_x) * SQ_W'(i_accel_x);
    assign sq_y = SQ_W'(i_accel_y) * SQ_W'(i_accel_y);
    assign sq_z = SQ_W'(i_accel_z) * SQ_W'(i_accel_z);
    assign mag  = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);

    always_comb begin
        n_pre.cmd           = t_cmd'(i_command);
        n_pre.system_status = i_system_status;
        n_pre.warn_ok       = in_window(pitch_ext, i_cfg.warn_pitch_bounds)
                            && in_window(roll_ext, i_cfg.warn_roll_bounds);
        n_pre.panic_ok      = in_window(pitch_ext, i_cfg.panic_pitch_bounds)
                            && in_window(roll_ext, i_cfg.panic_roll_bounds);
        n_pre.mag           = MAG_W'(mag);
    end

    // Hold the stage while the next stage stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pre <= n_pre;
        end
    end

    assign o_valid = r_valid;
    assign o_pre   = r_pre;

endmodule

// ----- sv/ftm_update.sv -----
`timescale 1ns / 1ps
// Monitor state update and result register: mode tracking, arm flag,
// elapsed counters and deadman timer. Depends on ftm_pkg.
module ftm_update (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  ftm_pkg::t_pre   i_pre,
    input  ftm_pkg::t_cfg   i_cfg,
    output logic            o_valid,
    output ftm_pkg::t_res   o_res
);
    import ftm_pkg::*;

    t_mode       r_mode;
    t_mode       n_mode;
    logic        r_arm;
    logic        n_arm;
    logic        r_sdelay;
    logic        n_sdelay;
    logic [15:0] r_warn;
    logic [15:0] n_warn;
    logic [15:0] r_fall;
    logic [15:0] n_fall;
    logic [15:0] r_dead;
    logic [15:0] n_dead;
    logic        r_valid;
    t_res        r_res;
    t_res        n_res;
    logic        acc_ok;

    assign acc_ok = i_pre.mag > i_cfg.freefall_threshold;

    // Apply one event to the monitor state
    always_comb begin
        n_mode   = r_mode;
        n_arm    = r_arm;
        n_sdelay = r_sdelay;
        n_warn   = r_warn;
        n_fall   = r_fall;
        n_dead   = r_dead;
        n_res    = '0;
        unique case (i_pre.cmd)
            CMD_HEARTBEAT: begin
                n_dead = i_cfg.deadman_ms;
                unique case (i_pre.system_status) inside
                    STS_BOOT:        n_mode = MODE_BOOT;
                    STS_CALIBRATING: n_mode = MODE_CAL;
                    STS_STANDBY: begin
                        // first standby after active only clears the delay
                        if (r_mode != MODE_STANDBY) begin
                            if (r_sdelay) begin
                                n_sdelay = 1'b0;
                            end else begin
                                n_res.disarm_pulse = 1'b1;
                                n_arm              = 1'b0;
                                n_mode             = MODE_STANDBY;
                            end
                        end
                    end
                    STS_ACTIVE: begin
                        if (r_mode == MODE_STANDBY) begin
                            n_res.rearm_pulse = 1'b1;
                            n_arm             = 1'b1;
                        end
                        n_sdelay = 1'b1;
                        n_mode   = MODE_ACTIVE;
                    end
                    STS_CRITICAL, STS_EMERGENCY: n_mode = MODE_EMERG;
                    STS_TERMINATION: begin
                        n_res.fire = 1'b1;
                        n_mode     = MODE_TERM;
                    end
                    default: ;
                endcase
            end
            CMD_ATTITUDE: begin
                n_warn        = i_pre.warn_ok ? 16'd0 : sat_add16(r_warn, i_cfg.time_step);
                n_res.fire    = !i_pre.panic_ok || (n_warn >= i_cfg.panic_delay_ms);
                n_res.warning = !i_pre.warn_ok;
            end
            CMD_ACCEL: begin
                n_fall        = acc_ok ? 16'd0 : sat_add16(r_fall, i_cfg.time_step);
                n_res.fire    = n_fall > i_cfg.panic_delay_ms;
                n_res.warning = !acc_ok;
            end
            CMD_TICK: begin
                // count down a running deadman, fire once on reaching zero
                if (r_dead != 16'd0) begin
                    n_dead     = r_dead - 16'd1;
                    n_res.fire = (r_dead == 16'd1);
                end
            end
            default: ;
        endcase
        n_res.armed = n_arm;
        n_res.mode  = mode_code(n_mode);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_UNINIT;
            r_arm    <= 1'b0;
            r_sdelay <= 1'b0;
            r_warn   <= 16'd0;
            r_fall   <= 16'd0;
            r_dead   <= 16'd0;
            r_valid  <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_mode   <= n_mode;
                r_arm    <= n_arm;
                r_sdelay <= n_sdelay;
                r_warn   <= n_warn;
                r_fall   <= n_fall;
                r_dead   <= n_dead;
            end
        end
    end

    // Result register, loaded with each transaction that advances
    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
